// ===== hdl/mop_pkg.sv =====
// ---------------------------------------------------------------------------
// mop_pkg
// Shared constants, types and helpers of the 3x3 binary opening pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package mop_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int GRAY_W     = 8;
    localparam int SIZE_W     = 12;
    localparam int MASK_W     = 9;
    localparam int WIN_N      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int W_W        = $clog2(MAX_WIDTH + 1);
    localparam int H_W        = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CNT_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
    localparam int CNT_IDX_W  = $clog2(CNT_W);
    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 1;
    localparam int HA_W       = $clog2(HIST_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK      = 2'd3;

    localparam logic OP_PIXEL = 1'b0;

    localparam logic [GRAY_W-1:0] RST_THRESHOLD = 8'd150;
    localparam logic [SIZE_W-1:0] RST_WIDTH     = 12'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT    = 12'd480;
    localparam logic [MASK_W-1:0] RST_MASK      = 9'd186;

    localparam int RST_WC    = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RST_HC    = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
    localparam int RST_TOTAL = RST_WC * RST_HC;

    typedef struct packed {
        logic              and_mode;
        logic              gate;
        logic [WIN_N-1:0]  care;
    } cell_ctl_t;

    typedef struct packed {
        logic              in_frame;
        logic              interior;
        logic              has_res;
        logic              last;
        logic [WIN_N-1:0]  inb;
    } pos_t;

    function automatic logic [W_W-1:0] clamp_w(input logic [SIZE_W-1:0] v);
        logic [W_W-1:0] r;
        if (v < SIZE_W'(3)) begin
            r = W_W'(3);
        end else if (32'(v) > MAX_WIDTH) begin
            r = W_W'(MAX_WIDTH);
        end else begin
            r = W_W'(v);
        end
        return r;
    endfunction

    function automatic logic [H_W-1:0] clamp_h(input logic [SIZE_W-1:0] v);
        logic [H_W-1:0] r;
        if (v < SIZE_W'(3)) begin
            r = H_W'(3);
        end else if (32'(v) > MAX_HEIGHT) begin
            r = H_W'(MAX_HEIGHT);
        end else begin
            r = H_W'(v);
        end
        return r;
    endfunction

    // element bit k faces window slot 8-k on the erosion side
    function automatic logic [WIN_N-1:0] rev_mask(input logic [WIN_N-1:0] m);
        logic [WIN_N-1:0] r;
        for (int k = 0; k < WIN_N; k++) begin
            r[k] = m[WIN_N-1-k];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mop_ram.sv =====
// ---------------------------------------------------------------------------
// mop_ram
// Generic RAM: one write port, two read ports with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module mop_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic      [WIDTH-1:0]                            rdata_a,
    output logic      [WIDTH-1:0]                            rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== hdl/mop_cell.sv =====
// ---------------------------------------------------------------------------
// mop_cell
// One window cell: keeps two rows of history of its input bit stream, forms
// the 3x3 window of the newest beat and reduces it by AND or OR.
// ---------------------------------------------------------------------------
`default_nettype none

module mop_cell import mop_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             bit_in,
    input  wire logic [W_W-1:0]   width,
    input  wire cell_ctl_t        ctl,
    output logic      [WIN_N-1:0] win,
    output logic                  result
);

    logic [HA_W-1:0] head_reg;
    logic [HA_W-1:0] head_next;
    logic [HA_W-1:0] head_inc;
    logic [HA_W-1:0] addr_w;
    logic [HA_W-1:0] addr_2w;
    logic [1:0]      hist_reg;
    logic [1:0]      hist_next;
    logic [2:0]      cur_reg;
    logic [2:0]      cur_next;
    logic [2:0]      triple;
    logic [2:0]      tap_w;
    logic [2:0]      tap_2w;

    function automatic logic [HA_W-1:0] back_addr(input logic [HA_W-1:0] h,
                                                  input logic [HA_W:0]   d);
        logic [HA_W:0] diff;
        diff = {1'b0, h} - d;
        if (diff[HA_W])
        begin
            diff = diff + (HA_W + 1)'(HIST_DEPTH);
        end
        return diff[HA_W-1:0];
    endfunction

    // newest bit at index 0, each RAM word holds three consecutive beats
    assign triple    = {hist_reg, bit_in};
    assign head_inc  = (head_reg == HA_W'(HIST_DEPTH - 1)) ? '0 : head_reg + HA_W'(1);
    assign head_next = adv ? head_inc : head_reg;
    assign hist_next = adv ? {hist_reg[0], bit_in} : hist_reg;
    assign cur_next  = adv ? triple : cur_reg;
    assign addr_w    = back_addr(head_inc, (HA_W + 1)'(width));
    assign addr_2w   = back_addr(head_inc, (HA_W + 1)'({width, 1'b0}));

    mop_ram #(
        .WIDTH (3),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk     (clk),
        .we      (adv),
        .waddr   (head_inc),
        .wdata   (triple),
        .re      (adv),
        .raddr_a (addr_w),
        .raddr_b (addr_2w),
        .rdata_a (tap_w),
        .rdata_b (tap_2w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            hist_reg <= '0;
            cur_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            hist_reg <= hist_next;
            cur_reg  <= cur_next;
        end
    end

    assign win = {tap_2w, tap_w, cur_reg};

    always_comb
    begin
        if (ctl.and_mode)
        begin
            result = ctl.gate & (&(win | ~ctl.care));
        end
        else
        begin
            result = ctl.gate & (|(win & ctl.care));
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mop_geom.sv =====
// ---------------------------------------------------------------------------
// mop_geom
// Frame position tracking: beat count, row and column of the input beat,
// and the border flags of the erosion and output positions.
// ---------------------------------------------------------------------------
`default_nettype none

module mop_geom import mop_pkg::*; (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           size_wr,
    input  wire logic [W_W-1:0] width,
    input  wire logic [H_W-1:0] height,
    input  wire logic           accept,
    output pos_t                pos,
    output logic                busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_DIV  = 3'b100
    } geom_st_t;

    geom_st_t             st_reg, st_next;
    logic [CNT_W-1:0]     i_reg, i_next;
    logic [CNT_W-1:0]     irow_reg, irow_next;
    logic [COL_W-1:0]     icol_reg, icol_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     thr_res_reg, thr_res_next;
    logic [CNT_W-1:0]     thr_ero_reg, thr_ero_next;
    logic [CNT_W-1:0]     thr_last_reg, thr_last_next;
    logic [CNT_IDX_W-1:0] cnt_reg, cnt_next;
    logic [COL_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     q_reg, q_next;

    logic [COL_W:0]       shifted;
    logic                 ge;
    logic [COL_W-1:0]     rem_step;
    logic [CNT_W-1:0]     q_step;

    logic [CNT_W-1:0]     hx;
    logic [COL_W-1:0]     w_m1;
    logic [CNT_W-1:0]     erow, orow;
    logic [COL_W-1:0]     ecol, ocol;
    logic [W_W-1:0]       icol_inc;
    logic [2:0]           r_ok, c_ok;
    logic                 ero_ok;

    // restoring division of the beat count by the width, one quotient bit a cycle
    assign shifted  = {rem_reg, i_reg[cnt_reg]};
    assign ge       = shifted >= (COL_W + 1)'(width);
    assign rem_step = ge ? COL_W'(shifted - (COL_W + 1)'(width)) : COL_W'(shifted);
    assign q_step   = {q_reg[CNT_W-2:0], ge};

    assign hx       = CNT_W'(height);
    assign w_m1     = COL_W'(width - W_W'(1));
    assign icol_inc = W_W'(icol_reg) + W_W'(1);
    assign ero_ok   = i_reg >= thr_ero_reg;

    always_comb
    begin
        if (icol_reg != '0)
        begin
            ecol = icol_reg - COL_W'(1);
            erow = irow_reg - CNT_W'(1);
        end
        else
        begin
            ecol = w_m1;
            erow = irow_reg - CNT_W'(2);
        end
        if (ecol != '0)
        begin
            ocol = ecol - COL_W'(1);
            orow = erow - CNT_W'(1);
        end
        else
        begin
            ocol = w_m1;
            orow = erow - CNT_W'(2);
        end

        r_ok[0] = (orow + CNT_W'(1)) < hx;
        r_ok[1] = orow < hx;
        r_ok[2] = (orow != '0) && (orow <= hx);
        c_ok[0] = (W_W'(ocol) + W_W'(1)) < width;
        c_ok[1] = 1'b1;
        c_ok[2] = ocol != '0;

        pos.in_frame = i_reg < total_reg;
        pos.has_res  = i_reg >= thr_res_reg;
        pos.last     = i_reg >= thr_last_reg;
        pos.interior = ero_ok && (erow != '0) && ((erow + CNT_W'(1)) < hx)
                       && (ecol != '0) && ((W_W'(ecol) + W_W'(1)) < width);
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                pos.inb[3 * dr + dc] = r_ok[dr] & c_ok[dc];
            end
        end
    end

    always_comb
    begin
        st_next       = st_reg;
        i_next        = i_reg;
        irow_next     = irow_reg;
        icol_next     = icol_reg;
        total_next    = total_reg;
        thr_res_next  = thr_res_reg;
        thr_ero_next  = thr_ero_reg;
        thr_last_next = thr_last_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;

        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pos.has_res && pos.last)
                    begin
                        i_next    = '0;
                        irow_next = '0;
                        icol_next = '0;
                    end
                    else
                    begin
                        i_next = i_reg + CNT_W'(1);
                        if (icol_inc == width)
                        begin
                            icol_next = '0;
                            irow_next = irow_reg + CNT_W'(1);
                        end
                        else
                        begin
                            icol_next = COL_W'(icol_inc);
                        end
                    end
                end
            end
            ST_MUL:
            begin
                total_next   = CNT_W'(width) * CNT_W'(height);
                thr_res_next = (CNT_W'(width) << 1) + CNT_W'(2);
                thr_ero_next = CNT_W'(width) + CNT_W'(1);
                cnt_next     = CNT_IDX_W'(CNT_W - 1);
                rem_next     = '0;
                q_next       = '0;
                st_next      = ST_DIV;
            end
            ST_DIV:
            begin
                thr_last_next = total_reg + (CNT_W'(width) << 1) + CNT_W'(1);
                rem_next      = rem_step;
                q_next        = q_step;
                cnt_next      = cnt_reg - CNT_IDX_W'(1);
                if (cnt_reg == '0)
                begin
                    irow_next = q_step;
                    icol_next = rem_step;
                    st_next   = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        if (size_wr)
        begin
            st_next = ST_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            i_reg        <= '0;
            irow_reg     <= '0;
            icol_reg     <= '0;
            total_reg    <= CNT_W'(RST_TOTAL);
            thr_res_reg  <= CNT_W'(2 * RST_WC + 2);
            thr_ero_reg  <= CNT_W'(RST_WC + 1);
            thr_last_reg <= CNT_W'(RST_TOTAL + 2 * RST_WC + 1);
            cnt_reg      <= '0;
            rem_reg      <= '0;
            q_reg        <= '0;
        end
        else
        begin
            st_reg       <= st_next;
            i_reg        <= i_next;
            irow_reg     <= irow_next;
            icol_reg     <= icol_next;
            total_reg    <= total_next;
            thr_res_reg  <= thr_res_next;
            thr_ero_reg  <= thr_ero_next;
            thr_last_reg <= thr_last_next;
            cnt_reg      <= cnt_next;
            rem_reg      <= rem_next;
            q_reg        <= q_next;
        end
    end

    assign busy = st_reg != ST_IDLE;

endmodule

`default_nettype wire

// ===== hdl/binary_morphological_opening_top.sv =====
// ---------------------------------------------------------------------------
// binary_morphological_opening_top
// Streaming 3x3 binary opening: threshold, erosion and dilation of a raster
// pixel stream with a programmable structuring element.
// ---------------------------------------------------------------------------
//   channel   handshake               payload
//   in        in_valid / in_ready     opcode, gray
//   out       out_valid / out_ready   binary_bit, eroded_bit, opened_bit, frame_end
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one beat per clock sustained while out_ready and the size logic allow; a beat passes
// stage 1, stage 2 and the output register, through the binary cell and the eroded cell
// result k of a frame comes with input beat k + 2*W + 2
// a width or height write holds in_ready low
// while the beat count is divided by the new width, one bit a cycle
// history RAMs need no clearing pass; while a result waits the two earlier
// stages still fill, then in_ready drops
// ---------------------------------------------------------------------------
`default_nettype none

module binary_morphological_opening_top import mop_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  opcode,
    input  wire logic [GRAY_W-1:0]     gray,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       binary_bit,
    output logic                       eroded_bit,
    output logic                       opened_bit,
    output logic                       frame_end,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [GRAY_W-1:0] threshold_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [MASK_W-1:0] mask_reg;

    logic [W_W-1:0]    w_cl;
    logic [H_W-1:0]    h_cl;
    logic              size_wr;
    logic              busy;
    pos_t              pos;

    logic              accept, adv1, adv2;
    logic              ready1, ready2, ready3;
    logic              v1_reg, v2_reg;
    pos_t              s1_pos_reg;
    logic              s2_res_reg, s2_last_reg, s2_bin_reg;
    logic [WIN_N-1:0]  s2_inb_reg;
    logic              out_valid_reg;
    logic              bin_out_reg, ero_out_reg, open_out_reg, last_out_reg;

    logic              bin_bit;
    cell_ctl_t         ctl_bin, ctl_ero;
    logic [WIN_N-1:0]  win_bin, win_ero;
    logic              ero_bit, open_bit;

    assign cfg_ready = 1'b1;
    assign size_wr   = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
    assign w_cl      = clamp_w(width_reg);
    assign h_cl      = clamp_h(height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= RST_THRESHOLD;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            mask_reg      <= RST_MASK;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[GRAY_W-1:0];
                REG_WIDTH:     width_reg     <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT:    height_reg    <= cfg_data[SIZE_W-1:0];
                REG_MASK:      mask_reg      <= cfg_data[MASK_W-1:0];
                default:       ;
            endcase
        end
    end

    mop_geom u_geom (
        .clk     (clk),
        .rst_n   (rst_n),
        .size_wr (size_wr),
        .width   (w_cl),
        .height  (h_cl),
        .accept  (accept),
        .pos     (pos),
        .busy    (busy)
    );

    assign ready3   = !out_valid_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign adv2     = v2_reg && ready3;
    assign adv1     = v1_reg && ready2;
    assign in_ready = ready1 && !busy;
    assign accept   = in_valid && in_ready;

    assign bin_bit  = (opcode == OP_PIXEL) && pos.in_frame && (gray > threshold_reg);

    assign ctl_bin.and_mode = 1'b1;
    assign ctl_bin.gate     = s1_pos_reg.interior;
    assign ctl_bin.care     = rev_mask(mask_reg);

    assign ctl_ero.and_mode = 1'b0;
    assign ctl_ero.gate     = 1'b1;
    assign ctl_ero.care     = mask_reg & s2_inb_reg;

    mop_cell u_cell_bin (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (accept),
        .bit_in (bin_bit),
        .width  (w_cl),
        .ctl    (ctl_bin),
        .win    (win_bin),
        .result (ero_bit)
    );

    mop_cell u_cell_ero (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv1),
        .bit_in (ero_bit),
        .width  (w_cl),
        .ctl    (ctl_ero),
        .win    (win_ero),
        .result (open_bit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= accept;
            end
            if (ready2)
            begin
                v2_reg <= adv1;
            end
            if (ready3)
            begin
                out_valid_reg <= adv2 && s2_res_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= pos;
        end
        if (adv1)
        begin
            s2_res_reg  <= s1_pos_reg.has_res;
            s2_last_reg <= s1_pos_reg.last;
            s2_inb_reg  <= s1_pos_reg.inb;
            s2_bin_reg  <= win_bin[WIN_N-1];
        end
        if (adv2)
        begin
            bin_out_reg  <= s2_bin_reg;
            ero_out_reg  <= win_ero[4];
            open_out_reg <= open_bit;
            last_out_reg <= s2_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign binary_bit = bin_out_reg;
    assign eroded_bit = ero_out_reg;
    assign opened_bit = open_out_reg;
    assign frame_end  = last_out_reg;

endmodule

`default_nettype wire

// ===== tb/sv/binary_morphological_opening_top_test.sv =====
// ---------------------------------------------------------------------------
// binary_morphological_opening_top_test
// Self-checking bench for the streaming 3x3 binary opening. A queue of pixel
// and register beats feeds a clocked driver. A clocked monitor keeps its own
// line history of binary and eroded bits, predicts every output beat and
// compares it with what the block returns. Both sides stall at random.
// ---------------------------------------------------------------------------
module binary_morphological_opening_top_test;
    import mop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic        OP_FLUSH      = ~OP_PIXEL;
    localparam int unsigned HIST_LEN      = 2 * MAX_WIDTH + 3;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CALM_TAIL     = 200;
    localparam int          RANDOM_BEATS  = 1000;
    localparam int          MAX_SHOWN     = 10;

    typedef enum logic [1:0] {CMD_BEAT, CMD_REG, CMD_PAUSE} stim_kind_t;

    typedef struct {
        stim_kind_t            kind;
        logic                  op;
        logic [GRAY_W-1:0]     g;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
    } stim_t;

    typedef struct packed {
        logic bin;
        logic ero;
        logic opened;
        logic last;
    } opened_px_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  opcode     = OP_PIXEL;
    logic [GRAY_W-1:0]     gray       = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic                  binary_bit;
    logic                  eroded_bit;
    logic                  opened_bit;
    logic                  frame_end;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // stimulus side
    stim_t       gray_beats[$];
    int unsigned plan_w   = RST_WIDTH;
    int unsigned plan_h   = RST_HEIGHT;
    int unsigned plan_thr = RST_THRESHOLD;
    int unsigned plan_pos = 0;
    int unsigned n_queued = 0;
    int          gap_left = 0;
    int          gap_pct  = 8;
    int          quiet_cycles = 0;

    // prediction side
    opened_px_t        due_pixels[$];
    bit                bin_hist[HIST_LEN];
    bit                ero_hist[HIST_LEN];
    int unsigned       hist_head;
    int unsigned       pix_count;
    logic [GRAY_W-1:0] cur_thr;
    logic [SIZE_W-1:0] cur_width;
    logic [SIZE_W-1:0] cur_height;
    logic [MASK_W-1:0] cur_mask;
    int                stall_left = 0;
    int                stall_pct  = 8;

    int n_bad       = 0;
    int n_checked   = 0;
    int n_beats     = 0;
    int n_regs      = 0;
    int n_frame_end = 0;

    binary_morphological_opening_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .gray       (gray),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .binary_bit (binary_bit),
        .eroded_bit (eroded_bit),
        .opened_bit (opened_bit),
        .frame_end  (frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
        if (v < 3)
        begin
            return 3;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic int unsigned hist_slot(input int unsigned d);
        return (hist_head + HIST_LEN - (d % HIST_LEN)) % HIST_LEN;
    endfunction

    // binarize, erode and dilate one beat; returns 1 when a result is due
    function automatic bit predict_opening(input logic op, input logic [GRAY_W-1:0] g,
                                           output opened_px_t r);
        int unsigned w, h, total, i, e, o, orow, ocol;
        int          nr, nc;
        bit          ero, opened;
        w     = fit_size(cur_width, MAX_WIDTH);
        h     = fit_size(cur_height, MAX_HEIGHT);
        total = w * h;
        i     = pix_count;
        r     = '0;
        hist_head = (hist_head + 1) % HIST_LEN;
        bin_hist[hist_head] = (op == OP_PIXEL) && (i < total) && (g > cur_thr);
        ero = 1'b0;
        if (i >= w + 1)
        begin
            e = i - w - 1;
            if (e / w >= 1 && e / w + 1 < h && e % w >= 1 && e % w + 1 < w)
            begin
                ero = 1'b1;
                for (int dr = 0; dr < 3; dr++)
                begin
                    for (int dc = 0; dc < 3; dc++)
                    begin
                        if (cur_mask[3 * dr + dc] &&
                            !bin_hist[hist_slot((2 - dr) * w + (2 - dc))])
                        begin
                            ero = 1'b0;
                        end
                    end
                end
            end
        end
        ero_hist[hist_head] = ero;
        pix_count = i + 1;
        if (i < 2 * w + 2)
        begin
            return 1'b0;
        end
        o    = i - 2 * w - 2;
        orow = o / w;
        ocol = o % w;
        r.bin = bin_hist[hist_slot(2 * w + 2)];
        r.ero = ero_hist[hist_slot(w + 1)];
        opened = 1'b0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                nr = int'(orow) + 1 - dr;
                nc = int'(ocol) + 1 - dc;
                if (cur_mask[3 * dr + dc] && nr >= 0 && nr < int'(h) && nc >= 0 &&
                    nc < int'(w) && ero_hist[hist_slot(dr * w + dc)])
                begin
                    opened = 1'b1;
                end
            end
        end
        r.opened = opened;
        r.last   = (o + 1 >= total);
        if (r.last)
        begin
            pix_count = 0;
        end
        return 1'b1;
    endfunction

    task automatic put_pixel(input logic op, input logic [GRAY_W-1:0] g);
        int unsigned w, h;
        w = fit_size(plan_w, MAX_WIDTH);
        h = fit_size(plan_h, MAX_HEIGHT);
        gray_beats.push_back('{kind: CMD_BEAT, op: op, g: g, idx: REG_THRESHOLD, val: '0});
        if (plan_pos >= 2 * w + 2 && plan_pos - 2 * w - 1 >= w * h)
        begin
            plan_pos = 0;
        end
        else
        begin
            plan_pos++;
        end
        n_queued++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        gray_beats.push_back('{kind: CMD_REG, op: OP_PIXEL, g: '0, idx: idx, val: val});
        case (idx)
            REG_THRESHOLD: plan_thr = val[GRAY_W-1:0];
            REG_WIDTH:     plan_w   = val;
            REG_HEIGHT:    plan_h   = val;
            default:       ;
        endcase
    endtask

    task automatic put_pause();
        gray_beats.push_back('{kind: CMD_PAUSE, op: OP_PIXEL, g: '0, idx: REG_THRESHOLD,
                               val: '0});
    endtask

    function automatic logic [GRAY_W-1:0] pick_gray(input int fg_pct);
        if (plan_thr >= 255)
        begin
            return GRAY_W'($urandom);
        end
        if ($urandom_range(0, 99) < fg_pct)
        begin
            return GRAY_W'($urandom_range(plan_thr + 1, 255));
        end
        return GRAY_W'($urandom_range(0, plan_thr));
    endfunction

    // flush any open frame, then one raster frame plus its flush tail, noise swaps pixels and flushes
    task automatic put_frame(input int fg_pct, input int noise_pct);
        int unsigned w, h;
        while (plan_pos != 0)
        begin
            put_pixel(OP_FLUSH, GRAY_W'($urandom));
        end
        w = fit_size(plan_w, MAX_WIDTH);
        h = fit_size(plan_h, MAX_HEIGHT);
        for (int unsigned k = 0; k < w * h; k++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                put_pixel(OP_FLUSH, GRAY_W'($urandom));
            end
            else
            begin
                put_pixel(OP_PIXEL, pick_gray(fg_pct));
            end
        end
        while (plan_pos != 0)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                put_pixel(OP_PIXEL, GRAY_W'($urandom));
            end
            else
            begin
                put_pixel(OP_FLUSH, GRAY_W'($urandom));
            end
        end
    endtask

    task automatic put_random_setup();
        int sel;
        if ($urandom_range(0, 3) != 0)
        begin
            sel = $urandom_range(0, 19);
            put_reg(REG_WIDTH, (sel == 0) ? CFG_DATA_W'($urandom_range(0, 2)) :
                               (sel == 1) ? CFG_DATA_W'($urandom_range(10, 24)) :
                                            CFG_DATA_W'($urandom_range(3, 9)));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            sel = $urandom_range(0, 19);
            put_reg(REG_HEIGHT, (sel == 0) ? CFG_DATA_W'($urandom_range(0, 2)) :
                                (sel == 1) ? CFG_DATA_W'($urandom_range(9, 16)) :
                                             CFG_DATA_W'($urandom_range(3, 8)));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            sel = $urandom_range(0, 9);
            put_reg(REG_THRESHOLD, {4'($urandom), (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 :
                                                  8'($urandom)});
        end
        if ($urandom_range(0, 2) != 0)
        begin
            sel = $urandom_range(0, 9);
            put_reg(REG_MASK, {3'($urandom), (sel == 0) ? 9'd0 : (sel == 1) ? 9'h1FF :
                                             (sel == 2) ? RST_MASK : 9'($urandom)});
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        stim_t nxt;
        logic  v_in, v_cfg;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            cfg_valid    <= 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end
        else
        begin
            v_in  = in_valid && !in_ready;
            v_cfg = cfg_valid && !cfg_ready;
            if (!in_valid && !cfg_valid && due_pixels.size() == 0)
            begin
                quiet_cycles++;
            end
            else
            begin
                quiet_cycles = 0;
            end
            if (!v_in && !v_cfg)
            begin
                if ($urandom_range(0, 127) == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       gap_pct = 0;
                        1:       gap_pct = 8;
                        default: gap_pct = 30;
                    endcase
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (gray_beats.size() > 0)
                begin
                    nxt = gray_beats[0];
                    if (nxt.kind == CMD_BEAT)
                    begin
                        v_in = 1'b1;
                        opcode <= nxt.op;
                        gray   <= nxt.g;
                        void'(gray_beats.pop_front());
                        if (gray_beats.size() > CALM_TAIL && $urandom_range(0, 99) < gap_pct)
                        begin
                            gap_left = $urandom_range(1, 12);
                        end
                    end
                    else if (quiet_cycles >= SETTLE_CYCLES)
                    begin
                        if (nxt.kind == CMD_REG)
                        begin
                            v_cfg = 1'b1;
                            cfg_index <= nxt.idx;
                            cfg_data  <= nxt.val;
                        end
                        void'(gray_beats.pop_front());
                        quiet_cycles = 0;
                    end
                end
            end
            in_valid  <= v_in;
            cfg_valid <= v_cfg;
        end
    end

    // monitor and predictor
    always @(posedge clk or negedge rst_n)
    begin : watch
        opened_px_t want, got;
        logic       rdy;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
            cur_thr    = RST_THRESHOLD;
            cur_width  = RST_WIDTH;
            cur_height = RST_HEIGHT;
            cur_mask   = RST_MASK;
            hist_head  = 0;
            pix_count  = 0;
            foreach (bin_hist[k])
            begin
                bin_hist[k] = 1'b0;
                ero_hist[k] = 1'b0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {binary_bit, eroded_bit, opened_bit, frame_end};
                if (due_pixels.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= MAX_SHOWN)
                    begin
                        $display("%0t: unexpected out beat bin %b ero %b open %b end %b",
                                 $realtime, got.bin, got.ero, got.opened, got.last);
                    end
                end
                else
                begin
                    want = due_pixels.pop_front();
                    n_checked++;
                    if (want.last)
                    begin
                        n_frame_end++;
                    end
                    if (got.bin !== want.bin || got.ero !== want.ero ||
                        got.opened !== want.opened || got.last !== want.last)
                    begin
                        n_bad++;
                        if (n_bad <= MAX_SHOWN)
                        begin
                            $display("%0t: out beat %0d expected bin %b ero %b open %b end %b, got bin %b ero %b open %b end %b",
                                     $realtime, n_checked, want.bin, want.ero, want.opened,
                                     want.last, got.bin, got.ero, got.opened, got.last);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                n_regs++;
                case (cfg_index)
                    REG_THRESHOLD: cur_thr    = cfg_data[GRAY_W-1:0];
                    REG_WIDTH:     cur_width  = cfg_data[SIZE_W-1:0];
                    REG_HEIGHT:    cur_height = cfg_data[SIZE_W-1:0];
                    REG_MASK:      cur_mask   = cfg_data[MASK_W-1:0];
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                n_beats++;
                if (predict_opening(opcode, gray, want))
                begin
                    due_pixels.push_back(want);
                end
            end
            if ($urandom_range(0, 127) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 8;
                    default: stall_pct = 30;
                endcase
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (gray_beats.size() > CALM_TAIL && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 11);
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            out_ready <= rdy;
        end
    end

    initial
    begin
        logic [GRAY_W-1:0] first_frame[9];
        int unsigned       rand_start;
        bit                first;
        first_frame = '{8'd0, 8'd255, 8'd151, 8'd255, 8'd255, 8'd255, 8'd150, 8'd255, 8'd0};

        // a few beats at reset sizes, then resize mid-frame
        put_pixel(OP_PIXEL, 8'd255);
        put_pixel(OP_PIXEL, 8'd150);
        put_pixel(OP_FLUSH, 8'd255);
        put_pixel(OP_PIXEL, 8'd151);
        put_reg(REG_WIDTH, 12'd3);
        put_reg(REG_HEIGHT, 12'd3);
        while (plan_pos != 0)
        begin
            put_pixel(OP_FLUSH, 8'd0);
        end
        // reset threshold and cross element, early flush in the last pixel
        for (int k = 0; k < 9; k++)
        begin
            put_pixel((k == 8) ? OP_FLUSH : OP_PIXEL, first_frame[k]);
        end
        put_pixel(OP_FLUSH, 8'd0);
        put_pixel(OP_PIXEL, 8'd255);
        while (plan_pos != 0)
        begin
            put_pixel(OP_FLUSH, 8'hFF);
        end
        put_pause();

        // widest line, clamped sizes and masked register data
        put_reg(REG_WIDTH, 12'hFFF);
        put_reg(REG_HEIGHT, 12'd0);
        put_reg(REG_THRESHOLD, 12'hF00);
        put_reg(REG_MASK, 12'hFFF);
        repeat (40)
        begin
            put_pixel(OP_PIXEL, GRAY_W'($urandom));
        end
        put_reg(REG_WIDTH, 12'(MAX_WIDTH));
        put_reg(REG_HEIGHT, 12'(MAX_HEIGHT));
        repeat (30)
        begin
            put_pixel(1'($urandom_range(0, 1)), GRAY_W'($urandom));
        end
        put_reg(REG_WIDTH, 12'd1);
        put_reg(REG_HEIGHT, 12'hFFF);
        repeat (40)
        begin
            put_pixel(1'($urandom_range(0, 1)), GRAY_W'($urandom));
        end
        put_reg(REG_HEIGHT, 12'd3);

        rand_start = n_queued;
        first = 1'b1;
        while (n_queued - rand_start < RANDOM_BEATS)
        begin
            if (first || $urandom_range(0, 2) == 0)
            begin
                put_random_setup();
                first = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                put_pause();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 20))
                begin
                    put_pixel(1'($urandom_range(0, 1)), GRAY_W'($urandom));
                end
            end
            put_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) :
                                                    $urandom_range(60, 100),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : 0);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (gray_beats.size() != 0 || in_valid || cfg_valid || due_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        $display("sent %0d pixel and flush beats with %0d register writes", n_beats, n_regs);
        $display("checked %0d output beats over %0d frame ends", n_checked, n_frame_end);
        if (n_bad == 0 && due_pixels.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches, %0d results never seen", n_bad, due_pixels.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("timeout with %0d beats queued, %0d results due", gray_beats.size(),
                 due_pixels.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
